// ===== src/drd_pkg.sv =====
// ----------------------------------------------------------------------------
// drd_pkg: shared definitions for the detector row decoder
// Field widths, register indexes, reset values and the pixel conversion
// helpers used by the decoder and its port checker.
// ----------------------------------------------------------------------------
package drd_pkg;

  localparam int unsigned ElemW    = 28;  // Q12.16 element
  localparam int unsigned ScaleW   = 16;  // Q4.12 scale
  localparam int unsigned ScoreW   = 17;  // Q1.16 score, up to 1.0
  localparam int unsigned ClassW   = 8;
  localparam int unsigned PosW     = 9;   // element position within a row
  localparam int unsigned GeomW    = ElemW + ScaleW;  // Q16.28 product
  localparam int unsigned GeomN    = 4;   // cx, cy, w, h
  localparam int unsigned GeomSelW = 2;
  localparam int unsigned EdgeAccW = GeomW + 2;       // 2*center - size, signed
  localparam int unsigned RowIdxW  = 14;
  localparam int unsigned EdgeW    = 16;
  localparam int unsigned SizeW    = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam int unsigned MaxRowsDefault = 16384;
  localparam logic [ClassW-1:0] MaxClasses = 8'd255;
  localparam logic [ScoreW-1:0] ScoreOne   = 17'h10000;

  // Register reset values.
  localparam logic                FormatModeRst = 1'b0;
  localparam logic [ClassW-1:0]   NumClassesDef = 8'd80;
  localparam logic [ScoreW-1:0]   ConfThreshRst = 17'd16384;
  localparam logic [ScaleW-1:0]   ScaleRst      = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORMAT_MODE    = 3'd0,
    CFG_NUM_CLASSES    = 3'd1,
    CFG_CONF_THRESHOLD = 3'd2,
    CFG_X_SCALE        = 3'd3,
    CFG_Y_SCALE        = 3'd4
  } cfg_idx_t;

  // Signed edge in units of 2^-29 pixel: truncate toward zero, saturate.
  function automatic logic signed [EdgeW-1:0] edge_px(input logic signed [EdgeAccW-1:0] v);
    logic [EdgeAccW-1:0] mag;
    logic [EdgeAccW-30:0] p;
    logic signed [EdgeW-1:0] res;
    mag = v[EdgeAccW-1] ? EdgeAccW'(-v) : EdgeAccW'(v);
    p   = mag[EdgeAccW-1:29];
    if (v[EdgeAccW-1]) begin
      if (p > (EdgeAccW-29)'(32768)) res = 16'sh8000;
      else                           res = EdgeW'(~p + 1'b1);
    end else begin
      if (p > (EdgeAccW-29)'(32767)) res = 16'sh7fff;
      else                           res = EdgeW'(p);
    end
    return res;
  endfunction

  // Q16.28 size: truncate to whole pixels, saturate.
  function automatic logic [SizeW-1:0] size_px(input logic [GeomW-1:0] g);
    logic [GeomW-29:0] p;
    p = g[GeomW-1:28];
    return (p > (GeomW-28)'(32767)) ? SizeW'(32767) : SizeW'(p);
  endfunction

endpackage

// ===== src/detector_row_decode_top.sv =====
// ----------------------------------------------------------------------------
// detector_row_decode_top: streaming decoder for detector output rows
// Takes one row element per transaction and emits at most one candidate box
// per row: best class, its score and the box scaled to image pixels.
// ----------------------------------------------------------------------------
// Pipeline: a result is registered from its closing element in the
// input register, so two register stages lie between the in_ and out_ ports.
// Throughput: one element per cycle, set by the single 28x28 multiplier and the
// running argmax update between the input register and the result register.
// A row-closing element waits only while an earlier result is still stalled.
// Reset (rst_n low, synchronous) empties both stages, clears counts, restores defaults.
module detector_row_decode_top
  #(parameter int unsigned MAX_ROWS = drd_pkg::MaxRowsDefault)
  (
  input  logic                                clk,
  input  logic                                rst_n,
  // element input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [drd_pkg::ElemW-1:0]           in_elem_value,
  input  logic                                in_frame_start,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [drd_pkg::RowIdxW-1:0]         out_row_index,
  output logic [drd_pkg::ClassW-1:0]          out_class_id,
  output logic [drd_pkg::ScoreW-1:0]          out_score,
  output logic signed [drd_pkg::EdgeW-1:0]    out_box_left,
  output logic signed [drd_pkg::EdgeW-1:0]    out_box_top,
  output logic [drd_pkg::SizeW-1:0]           out_box_width,
  output logic [drd_pkg::SizeW-1:0]           out_box_height,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [drd_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [drd_pkg::CfgDataW-1:0]        cfg_data
  );

  import drd_pkg::*;

  localparam int unsigned RowW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RowExtW = (RowW > RowIdxW) ? RowW : RowIdxW;
  localparam logic [RowW-1:0] RowLast = RowW'(MAX_ROWS - 1);
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned ScW     = ProdW - 16;

  // Configuration registers. The port never pushes back.
  logic              fmt_r;
  logic [ClassW-1:0] ncls_r;
  logic [ScoreW-1:0] thr_r;
  logic [ScaleW-1:0] xs_r;
  logic [ScaleW-1:0] ys_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FormatModeRst;
      ncls_r <= NumClassesDef;
      thr_r  <= ConfThreshRst;
      xs_r   <= ScaleRst;
      ys_r   <= ScaleRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FORMAT_MODE:    fmt_r  <= cfg_data[0];
        CFG_NUM_CLASSES:    ncls_r <= cfg_data[ClassW-1:0];
        CFG_CONF_THRESHOLD: thr_r  <= cfg_data[ScoreW-1:0];
        CFG_X_SCALE:        xs_r   <= cfg_data[ScaleW-1:0];
        CFG_Y_SCALE:        ys_r   <= cfg_data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Input register. It refills in the same cycle in which its item moves on,
  // so a stalled result does not hold up elements that close no row.
  logic             in_vld_r;
  logic [ElemW-1:0] in_elem_r;
  logic             in_fs_r;
  logic             go;
  logic             step;

  assign in_stall = in_vld_r && !go;
  assign step     = in_vld_r && go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= (in_valid && !in_stall) || (in_vld_r && !go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_elem_r <= in_elem_value;
      in_fs_r   <= in_frame_start;
    end
  end

  // Row state.
  logic [PosW-1:0]   elem_pos_r,   elem_pos_nxt;
  logic [RowW-1:0]   row_cnt_r,    row_cnt_nxt;
  logic [ElemW-1:0]  obj_r,        obj_nxt;
  logic              skip_r,       skip_nxt;
  logic [ScoreW-1:0] best_r,       best_nxt;
  logic [ClassW-1:0] bcls_r,       bcls_nxt;
  logic [GeomW-1:0]  geom_r [GeomN];

  // A frame start restarts the counts before this element is used.
  logic [PosW-1:0]   pos;
  logic [RowW-1:0]   row_cur;
  logic              skip_cur;
  logic [ScoreW-1:0] best_cur;
  logic [ClassW-1:0] bcls_cur;

  assign pos      = in_fs_r ? '0 : elem_pos_r;
  assign row_cur  = in_fs_r ? '0 : row_cnt_r;
  assign skip_cur = in_fs_r ? 1'b0 : skip_r;
  assign best_cur = in_fs_r ? '0 : best_r;
  assign bcls_cur = in_fs_r ? '0 : bcls_r;

  // Classify the element by its position under the current registers.
  logic [ClassW-1:0] ncls_eff;
  logic [ClassW-1:0] last_cidx;
  logic [PosW-1:0]   cls_base;
  logic [PosW-1:0]   cidx_raw;
  logic [ClassW-1:0] cidx;
  logic              geom_ph;
  logic              obj_ph;
  logic              cls_ph;
  logic              row_end;

  always_comb begin
    if (ncls_r == '0)             ncls_eff = ClassW'(1);
    else if (ncls_r > MaxClasses) ncls_eff = MaxClasses;
    else                          ncls_eff = ncls_r;
    last_cidx = ncls_eff - ClassW'(1);
    cls_base  = PosW'(GeomN) + PosW'(fmt_r);
    geom_ph   = pos < PosW'(GeomN);
    obj_ph    = !geom_ph && fmt_r && (pos == PosW'(GeomN));
    cls_ph    = !geom_ph && !obj_ph;
    cidx_raw  = (pos >= cls_base) ? (pos - cls_base) : '0;
    // Any position at or past the last class closes the row as that class.
    row_end   = cls_ph && (cidx_raw >= PosW'(last_cidx));
    cidx      = row_end ? last_cidx : cidx_raw[ClassW-1:0];
  end

  // One shared multiplier: value*scale for geometry, value*objectness for
  // class scores in mode 1.
  logic [ElemW-1:0]  mul_b;
  logic [ProdW-1:0]  prod;
  logic [ScW-1:0]    sc_raw;
  logic [ScoreW-1:0] sc;
  logic [ScoreW-1:0] best_new;
  logic [ClassW-1:0] bcls_new;
  logic              emit;

  always_comb begin
    if (geom_ph) mul_b = ElemW'(pos[0] ? ys_r : xs_r);
    else         mul_b = obj_r;
    prod   = ProdW'(in_elem_r) * ProdW'(mul_b);
    sc_raw = fmt_r ? prod[ProdW-1:16] : ScW'(in_elem_r);
    sc     = (sc_raw > ScW'(ScoreOne)) ? ScoreOne : sc_raw[ScoreW-1:0];
    // Strict compare keeps the earlier class on a tie.
    if (sc > best_cur) begin
      best_new = sc;
      bcls_new = cidx;
    end else begin
      best_new = best_cur;
      bcls_new = bcls_cur;
    end
    emit = row_end && !skip_cur && (best_new >= thr_r);
  end

  // Only a row-closing element needs the result register to be free.
  assign go = !row_end || !out_valid || !out_stall;

  always_comb begin
    elem_pos_nxt = elem_pos_r;
    row_cnt_nxt  = row_cnt_r;
    obj_nxt      = obj_r;
    skip_nxt     = skip_r;
    best_nxt     = best_r;
    bcls_nxt     = bcls_r;
    if (step) begin
      elem_pos_nxt = pos + PosW'(1);
      row_cnt_nxt  = row_cur;
      skip_nxt     = skip_cur;
      best_nxt     = best_cur;
      bcls_nxt     = bcls_cur;
      if (obj_ph) begin
        obj_nxt  = in_elem_r;
        skip_nxt = in_elem_r < ElemW'(thr_r);
      end else if (cls_ph) begin
        best_nxt = best_new;
        bcls_nxt = bcls_new;
      end
      if (row_end) begin
        elem_pos_nxt = '0;
        skip_nxt     = 1'b0;
        best_nxt     = '0;
        bcls_nxt     = '0;
        row_cnt_nxt  = (row_cur == RowLast) ? '0 : row_cur + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_pos_r <= '0;
      row_cnt_r  <= '0;
      obj_r      <= '0;
      skip_r     <= 1'b0;
      best_r     <= '0;
      bcls_r     <= '0;
    end else begin
      elem_pos_r <= elem_pos_nxt;
      row_cnt_r  <= row_cnt_nxt;
      obj_r      <= obj_nxt;
      skip_r     <= skip_nxt;
      best_r     <= best_nxt;
      bcls_r     <= bcls_nxt;
    end
  end

  // Scaled geometry, Q16.28. Every row writes all four entries before it can
  // close, so it needs no reset.
  always_ff @(posedge clk) begin
    if (step && geom_ph) begin
      geom_r[pos[GeomSelW-1:0]] <= prod[GeomW-1:0];
    end
  end

  // Box in pixels from the stored geometry: left = (2*cx - w)/2 with the
  // halving folded into the shift.
  logic signed [EdgeAccW-1:0] lx_acc;
  logic signed [EdgeAccW-1:0] ty_acc;
  logic [RowExtW-1:0]         row_ext;

  assign lx_acc  = $signed({1'b0, geom_r[0], 1'b0}) - $signed({2'b00, geom_r[2]});
  assign ty_acc  = $signed({1'b0, geom_r[1], 1'b0}) - $signed({2'b00, geom_r[3]});
  assign row_ext = RowExtW'(row_cur);

  // Result register.
  logic out_valid_r;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && out_stall) || (step && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_row_index  <= row_ext[RowIdxW-1:0];
      out_class_id   <= bcls_new;
      out_score      <= best_new;
      out_box_left   <= edge_px(lx_acc);
      out_box_top    <= edge_px(ty_acc);
      out_box_width  <= size_px(geom_r[2]);
      out_box_height <= size_px(geom_r[3]);
    end
  end

endmodule

// ===== src/drd_checker.sv =====
// ----------------------------------------------------------------------------
// drd_checker: port-level checks for the detector row decoder
// Watches the result channel and reset, and is bound to the top level.
// ----------------------------------------------------------------------------
module drd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [drd_pkg::ClassW-1:0]       out_class_id,
  input logic [drd_pkg::ScoreW-1:0]       out_score,
  input logic signed [drd_pkg::EdgeW-1:0] out_box_left,
  input logic [drd_pkg::SizeW-1:0]        out_box_width
  );

  import drd_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its score, class, left edge and width.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_score) && $stable(out_class_id)
                               && $stable(out_box_left) && $stable(out_box_width))
    else $error("result payload changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Scores saturate at one.
  a_score_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score <= ScoreOne)
    else $error("score above one");

  // The class index stays below MaxClasses, the ceiling of the class count.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_class_id < MaxClasses)
    else $error("class index out of range");

endmodule

bind detector_row_decode_top drd_checker u_drd_checker (.*);
